// ===== src/cbe_pkg.sv =====
// Shared types, widths and constants for the cubic Bezier 1D extrema block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int VW     = 32;          // value width, signed
  localparam int FB     = 16;          // fraction bits of the curve parameter
  localparam int MW     = VW + 1;      // magnitude of a control difference
  localparam int DSW    = 2 * MW;      // discriminant width
  localparam int DW     = VW + 5;      // divider operand width, signed
  localparam int PW     = MW + FB + 1; // lerp product width
  localparam int QDEPTH = 4;           // queue depth, power of two
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [VW-1:0] val_t;
  typedef logic [FB:0]          par_t;
  typedef logic signed [DW-1:0] num_t;

  localparam par_t T_ONE = {1'b1, {FB{1'b0}}};

  // classified segment, as it sits in the queue
  typedef struct packed {
    val_t             v0;
    val_t             v1;
    val_t             v2;
    val_t             v3;
    logic [MW-1:0]    ma;
    logic [MW-1:0]    mb;
    logic [MW-1:0]    mc;
    logic             ac_neg;
    num_t             den;
    num_t             num0;
    num_t             n3;
    num_t             d3;
    logic             min_sc;
    logic             min_end;
    logic             max_sc;
    logic             max_end;
  } front_t;

  // segment with its interior candidates solved
  typedef struct packed {
    front_t           f;
    par_t [2:0]       t;
    logic [2:0]       ok;
  } ctx_t;

endpackage

// ===== src/cubic_bezier_1d_extrema.sv =====
// Top level of the cubic Bezier 1D extrema block: front end, queue, solver
// and evaluator pipelines. Depends on cbe_pkg and all cbe_* modules.
`timescale 1ns / 1ps

// Usage
//  Input channel: in_valid/in_stall carry one segment per transaction
//  (start value, two control values, end value, signed Q16.16). Output
//  channel: out_valid/out_stall carry one result per segment: parameter
//  (Q1.16, 65536 = 1.0) and value of the minimum and of the maximum.
//  Results come out in input order.
//  The pipeline holds the square root (one result bit per stage over
//  the 66-bit discriminant), the 16-step restoring dividers and the
//  six-stage evaluator.
//  Throughput: one segment per cycle while the output is not stalled.
//  When the receiver asserts out_stall while out_valid is high, the
//  solver/evaluator pipeline freezes with the result held; the front
//  end keeps filling the 4-entry queue, and in_stall rises only when
//  the front register and the queue are both full.
//  Reset (rst_n low, synchronous) empties the pipeline and the queue.

module cubic_bezier_1d_extrema (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cbe_pkg::val_t in_start_value,
  input  cbe_pkg::val_t in_first_control,
  input  cbe_pkg::val_t in_second_control,
  input  cbe_pkg::val_t in_end_value,
  output logic          out_valid,
  input  logic          out_stall,
  output cbe_pkg::par_t out_min_param,
  output cbe_pkg::val_t out_min_result,
  output cbe_pkg::par_t out_max_param,
  output cbe_pkg::val_t out_max_result
);
  import cbe_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  front_t q_wdata;
  front_t q_rdata;
  logic   adv;
  logic   sv_v;
  ctx_t   sv_c;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  cbe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .start_value    (in_start_value),
    .first_control  (in_first_control),
    .second_control (in_second_control),
    .end_value      (in_end_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  cbe_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  cbe_solve u_solve (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (q_pop),
    .in_f  (q_rdata),
    .out_v (sv_v),
    .out_c (sv_c)
  );

  cbe_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_v       (sv_v),
    .in_c       (sv_c),
    .out_v      (out_valid),
    .min_param  (out_min_param),
    .min_result (out_min_result),
    .max_param  (out_max_param),
    .max_result (out_max_result)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue read while output is stalled");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_result <= out_max_result))
    else $error("minimum above maximum");

endmodule

// ===== src/cbe_front.sv =====
// Front end: takes input transactions, computes the control differences and
// derived numerators/denominators, and decides the endpoint shortcuts.
// Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cbe_pkg::val_t   start_value,
  input  cbe_pkg::val_t   first_control,
  input  cbe_pkg::val_t   second_control,
  input  cbe_pkg::val_t   end_value,
  input  logic            q_full,
  output logic            q_push,
  output cbe_pkg::front_t q_data
);
  import cbe_pkg::*;

  logic   fr_v_r;
  logic   fr_v_nxt;
  logic   load;
  front_t fr_r;
  front_t fr_nxt;
  num_t   a;
  num_t   b;
  num_t   c;

  function automatic num_t sx(val_t x);
    return num_t'(x);
  endfunction

  function automatic logic [DW-1:0] mag(num_t x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  assign q_push   = fr_v_r && !q_full;
  assign in_stall = fr_v_r && q_full;
  assign load     = in_valid && !in_stall;
  assign q_data   = fr_r;

  always_comb begin
    a = sx(first_control) - sx(start_value);
    b = sx(second_control) - sx(first_control);
    c = sx(end_value) - sx(second_control);
    fr_nxt.v0     = start_value;
    fr_nxt.v1     = first_control;
    fr_nxt.v2     = second_control;
    fr_nxt.v3     = end_value;
    fr_nxt.ma     = MW'(mag(a));
    fr_nxt.mb     = MW'(mag(b));
    fr_nxt.mc     = MW'(mag(c));
    fr_nxt.ac_neg = a[DW-1] ^ c[DW-1];
    fr_nxt.den    = a - (b <<< 1) + c;
    fr_nxt.num0   = a - b;
    fr_nxt.n3     = num_t'(3) * sx(second_control) - num_t'(2) * sx(start_value)
                    - sx(end_value);
    fr_nxt.d3     = num_t'(6) * sx(second_control) - num_t'(2) * sx(start_value)
                    - num_t'(4) * sx(end_value);
    fr_nxt.min_sc = (start_value <= first_control && start_value <= second_control) ||
                    (end_value <= first_control && end_value <= second_control);
    fr_nxt.min_end = end_value < start_value;
    fr_nxt.max_sc = (start_value >= first_control && start_value >= second_control) ||
                    (end_value >= first_control && end_value >= second_control);
    fr_nxt.max_end = end_value > start_value;
  end

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (load) begin
      fr_v_nxt = 1'b1;
    end else if (q_push) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_r <= fr_nxt;
    end
  end

endmodule

// ===== src/cbe_fifo.sv =====
// Short queue between the front end and the solver/evaluator pipeline.
// Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cbe_pkg::front_t wr_data,
  input  logic            pop,
  output cbe_pkg::front_t rd_data,
  output logic            full,
  output logic            empty
);
  import cbe_pkg::*;

  front_t         mem_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;
  logic [QAW:0]   cnt_nxt;

  assign full    = cnt_r == (QAW+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== src/cbe_solve.sv =====
// Solver pipeline: discriminant products, bit-pair square root, then three
// restoring dividers giving the interior candidates t1, t2, t3.
// Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_solve (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  cbe_pkg::front_t in_f,
  output logic            out_v,
  output cbe_pkg::ctx_t   out_c
);
  import cbe_pkg::*;

  localparam int RW = MW + 3;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [MW-1:0]  root;
    logic [DSW-1:0] d;
  } sq_t;

  typedef struct packed {
    logic          done;
    par_t          t;
    logic [DW-1:0] r;
    logic [DW-1:0] ud;
  } dv_t;

  function automatic logic [DW-1:0] mag(num_t x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  function automatic sq_t sq_step(sq_t s);
    logic [RW-1:0] r2;
    logic [RW-1:0] tr;
    sq_t           o;
    r2   = {s.rem[RW-3:0], s.d[DSW-1 -: 2]};
    tr   = {1'b0, s.root, 2'b01};
    o.d  = {s.d[DSW-3:0], 2'b00};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {s.root[MW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[MW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_init(num_t n, num_t d);
    dv_t o;
    o.r    = mag(n);
    o.ud   = mag(d);
    o.t    = '0;
    o.done = 1'b0;
    if (n == '0 || d == '0 || (n[DW-1] != d[DW-1])) begin
      o.done = 1'b1;
    end else if (o.r >= o.ud) begin
      o.done = 1'b1;
      o.t    = T_ONE;
    end
    return o;
  endfunction

  function automatic dv_t div_step(dv_t s);
    logic [DW:0] r2;
    dv_t         o;
    o = s;
    if (!s.done) begin
      r2  = {s.r, 1'b0};
      o.t = {s.t[FB-1:0], 1'b0};
      if (r2 >= {1'b0, s.ud}) begin
        r2     = r2 - {1'b0, s.ud};
        o.t[0] = 1'b1;
      end
      o.r = r2[DW-1:0];
    end
    return o;
  endfunction

  // product stage
  logic           m_v_r;
  front_t         m_f_r;
  logic [DSW-1:0] bb_r;
  logic [DSW-1:0] ac_r;

  // root stages
  logic   sq_v_r  [0:MW];
  front_t sq_f_r  [0:MW];
  logic   sq_ok_r [0:MW];
  sq_t    sq_r    [0:MW];
  sq_t    sq0_nxt;
  logic   ok_nxt;

  // divider stages
  logic   dv_v_r  [0:FB];
  front_t dv_f_r  [0:FB];
  logic   dv_ok_r [0:FB];
  dv_t    dv_r    [0:FB][0:2];
  num_t   s_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_f_r <= in_f;
      bb_r  <= DSW'(in_f.mb) * DSW'(in_f.mb);
      ac_r  <= DSW'(in_f.ma) * DSW'(in_f.mc);
    end
  end

  always_comb begin
    ok_nxt      = (m_f_r.den != '0) && (m_f_r.ac_neg || ac_r <= bb_r);
    sq0_nxt.rem  = '0;
    sq0_nxt.root = '0;
    sq0_nxt.d    = m_f_r.ac_neg ? bb_r + ac_r : bb_r - ac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_f_r[0]  <= m_f_r;
      sq_ok_r[0] <= ok_nxt;
      sq_r[0]    <= sq0_nxt;
    end
  end

  for (genvar k = 0; k < MW; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_f_r[k+1]  <= sq_f_r[k];
        sq_ok_r[k+1] <= sq_ok_r[k];
        sq_r[k+1]    <= sq_step(sq_r[k]);
      end
    end
  end

  assign s_ext = num_t'({1'b0, sq_r[MW].root});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_f_r[0]  <= sq_f_r[MW];
      dv_ok_r[0] <= sq_ok_r[MW];
      dv_r[0][0] <= div_init(sq_f_r[MW].num0 + s_ext, sq_f_r[MW].den);
      dv_r[0][1] <= div_init(sq_f_r[MW].num0 - s_ext, sq_f_r[MW].den);
      dv_r[0][2] <= div_init(sq_f_r[MW].n3, sq_f_r[MW].d3);
    end
  end

  for (genvar k = 0; k < FB; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_r[k+1][j] <= div_step(dv_r[k][j]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_f_r[k+1]  <= dv_f_r[k];
        dv_ok_r[k+1] <= dv_ok_r[k];
      end
    end
  end

  always_comb begin
    out_v       = dv_v_r[FB];
    out_c.f     = dv_f_r[FB];
    out_c.t[0]  = dv_r[FB][0].t;
    out_c.t[1]  = dv_r[FB][1].t;
    out_c.t[2]  = dv_r[FB][2].t;
    out_c.ok[0] = dv_ok_r[FB];
    out_c.ok[1] = dv_ok_r[FB];
    out_c.ok[2] = dv_f_r[FB].d3 != '0;
  end

endmodule

// ===== src/cbe_eval.sv =====
// Evaluator pipeline: de Casteljau evaluation of the three interior candidates
// (multiply and add on separate stages), then min/max selection into the
// output register. Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_eval (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  cbe_pkg::ctx_t in_c,
  output logic          out_v,
  output cbe_pkg::par_t min_param,
  output cbe_pkg::val_t min_result,
  output cbe_pkg::par_t max_param,
  output cbe_pkg::val_t max_result
);
  import cbe_pkg::*;

  typedef struct packed {
    val_t          x;
    logic [PW-1:0] p;
    logic          neg;
  } lm_t;

  // product half of x + floor((y - x) * t / ONE)
  function automatic lm_t lerp_mul(val_t x, val_t y, par_t t);
    logic [MW-1:0] d;
    logic [MW-1:0] m;
    lm_t           o;
    d     = {y[VW-1], y} - {x[VW-1], x};
    m     = d[MW-1] ? -d : d;
    o.x   = x;
    o.neg = d[MW-1];
    o.p   = PW'(m) * PW'(t);
    return o;
  endfunction

  // floor of a negative step rounds the magnitude up
  function automatic val_t lerp_add(lm_t l);
    logic [MW:0] q;
    logic [MW:0] xe;
    logic [MW:0] r;
    q  = l.p[PW-1:FB];
    xe = {{2{l.x[VW-1]}}, l.x};
    if (l.neg && (l.p[FB-1:0] != '0)) begin
      q = q + 1'b1;
    end
    r = l.neg ? xe - q : xe + q;
    return r[VW-1:0];
  endfunction

  logic v_r  [0:5];
  ctx_t cx_r [0:5];
  lm_t  lm1_r [0:2][0:2];
  val_t q1_r  [0:2][0:2];
  lm_t  lm2_r [0:2][0:1];
  val_t q2_r  [0:2][0:1];
  lm_t  lm3_r [0:2];
  val_t q3_r  [0:2];
  val_t pts [0:3];

  logic out_v_r;
  par_t min_t_r;
  val_t min_val_r;
  par_t max_t_r;
  val_t max_val_r;
  par_t min_t_nxt;
  val_t min_val_nxt;
  par_t max_t_nxt;
  val_t max_val_nxt;

  assign pts[0] = in_c.f.v0;
  assign pts[1] = in_c.f.v1;
  assign pts[2] = in_c.f.v2;
  assign pts[3] = in_c.f.v3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= in_c;
    end
  end

  for (genvar s = 1; s < 6; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r[s] <= cx_r[s-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_cand
    for (genvar k = 0; k < 3; k++) begin : g_l1
      always_ff @(posedge clk) begin
        if (adv) begin
          lm1_r[j][k] <= lerp_mul(pts[k], pts[k+1], in_c.t[j]);
          q1_r[j][k]  <= lerp_add(lm1_r[j][k]);
        end
      end
    end

    for (genvar k = 0; k < 2; k++) begin : g_l2
      always_ff @(posedge clk) begin
        if (adv) begin
          lm2_r[j][k] <= lerp_mul(q1_r[j][k], q1_r[j][k+1], cx_r[1].t[j]);
          q2_r[j][k]  <= lerp_add(lm2_r[j][k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lm3_r[j] <= lerp_mul(q2_r[j][0], q2_r[j][1], cx_r[3].t[j]);
        q3_r[j]  <= lerp_add(lm3_r[j]);
      end
    end
  end

  // endpoints, then interior candidates; ties keep the first; shortcuts win
  always_comb begin
    min_t_nxt   = '0;
    min_val_nxt = cx_r[5].f.v0;
    max_t_nxt   = '0;
    max_val_nxt = cx_r[5].f.v0;
    if (cx_r[5].f.v3 < min_val_nxt) begin
      min_t_nxt   = T_ONE;
      min_val_nxt = cx_r[5].f.v3;
    end
    if (cx_r[5].f.v3 > max_val_nxt) begin
      max_t_nxt   = T_ONE;
      max_val_nxt = cx_r[5].f.v3;
    end
    for (int j = 0; j < 3; j++) begin
      if (cx_r[5].ok[j] && q3_r[j] < min_val_nxt) begin
        min_t_nxt   = cx_r[5].t[j];
        min_val_nxt = q3_r[j];
      end
      if (cx_r[5].ok[j] && q3_r[j] > max_val_nxt) begin
        max_t_nxt   = cx_r[5].t[j];
        max_val_nxt = q3_r[j];
      end
    end
    if (cx_r[5].f.min_sc) begin
      min_t_nxt   = cx_r[5].f.min_end ? T_ONE : '0;
      min_val_nxt = cx_r[5].f.min_end ? cx_r[5].f.v3 : cx_r[5].f.v0;
    end
    if (cx_r[5].f.max_sc) begin
      max_t_nxt   = cx_r[5].f.max_end ? T_ONE : '0;
      max_val_nxt = cx_r[5].f.max_end ? cx_r[5].f.v3 : cx_r[5].f.v0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      min_t_r   <= min_t_nxt;
      min_val_r <= min_val_nxt;
      max_t_r   <= max_t_nxt;
      max_val_r <= max_val_nxt;
    end
  end

  assign out_v      = out_v_r;
  assign min_param  = min_t_r;
  assign min_result = min_val_r;
  assign max_param  = max_t_r;
  assign max_result = max_val_r;

endmodule
